### design/rbks_pkg.sv
// Shared types and constants for the record block key search unit.
// No dependencies; rbks_scan and the top level import this package.
package rbks_pkg;

  localparam int LEN_W = 32;
  localparam int VLEN_W = 31;
  localparam logic [LEN_W-1:0] MAX_REC_LEN = 32'h7FFF_FFFF;

  typedef enum logic [0:0] {
    REQ_KEY   = 1'b0,
    REQ_BLOCK = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    KIND_VALUE     = 2'd0,
    KIND_FOUND     = 2'd1,
    KIND_NOTFOUND  = 2'd2,
    KIND_MALFORMED = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    PH_LEN   = 3'd0,
    PH_KLEN  = 3'd1,
    PH_KEY   = 3'd2,
    PH_VALUE = 3'd3,
    PH_SKIP  = 3'd4,
    PH_DONE  = 3'd5
  } phase_t;

  typedef struct packed {
    req_t       req_type;
    logic [7:0] data_byte;
    logic       is_last;
  } in_t;

  typedef struct packed {
    kind_t             kind;
    logic [7:0]        value_byte;
    logic [VLEN_W-1:0] value_len;
    logic              final_res;
  } out_t;

  // Results caused by one block byte: up to two, r0 delivered first.
  typedef struct packed {
    logic [1:0] cnt;
    out_t       r0;
    out_t       r1;
  } res_pair_t;

endpackage

### design/rbks_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module rbks_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/rbks_scan.sv
// Key store and record parser: processes one key or block byte per step.
// Depends on rbks_pkg and rbks_ram.
module rbks_scan
  import rbks_pkg::*;
#(
  parameter int KEY_CAPACITY       = 128,
  parameter int LENGTH_FIELD_BYTES = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  in_t       item,
  output res_pair_t res
);

  localparam int AW  = $clog2(KEY_CAPACITY);
  localparam int KLW = $clog2(KEY_CAPACITY + 1);
  localparam int BW  = $clog2(LENGTH_FIELD_BYTES + 1);
  localparam int HDR = LENGTH_FIELD_BYTES + 1;

  // key state
  logic [KLW-1:0]    key_len_r, key_len_nxt;
  logic              key_over_r, key_over_nxt;
  logic              key_closed_r, key_closed_nxt;
  // scan state
  phase_t            phase_r, phase_nxt;
  logic [BW-1:0]     bir_r, bir_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [VLEN_W-1:0] rem_r, rem_nxt;
  logic [VLEN_W-1:0] vlen_r, vlen_nxt;
  logic [7:0]        cand_r, cand_nxt;
  logic [AW-1:0]     kidx_r, kidx_nxt;
  logic              eq_r, eq_nxt;
  logic              done_r, done_nxt;

  logic              we;
  logic [AW-1:0]     waddr;
  logic [AW-1:0]     raddr;
  logic [7:0]        key_rdata;

  logic              emit_val;
  logic              fin_en;
  kind_t             fin_kind;
  logic [VLEN_W-1:0] fin_len;

  logic [KLW-1:0]    klen_base;
  logic [LEN_W-1:0]  len_upd;
  logic [VLEN_W-1:0] rem_dec;
  logic              ak;
  logic [VLEN_W-1:0] ak_rem;
  logic [7:0]        b;

  assign b = item.data_byte;

  // Read ahead at the index the next key byte will compare against.
  assign raddr = step ? kidx_nxt : kidx_r;

  rbks_ram #(
    .WIDTH (8),
    .DEPTH (KEY_CAPACITY)
  ) u_key_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (b),
    .raddr (raddr),
    .rdata (key_rdata)
  );

  // Next state
  always_comb begin
    key_len_nxt    = key_len_r;
    key_over_nxt   = key_over_r;
    key_closed_nxt = key_closed_r;
    phase_nxt      = phase_r;
    bir_nxt        = bir_r;
    len_nxt        = len_r;
    rem_nxt        = rem_r;
    vlen_nxt       = vlen_r;
    cand_nxt       = cand_r;
    kidx_nxt       = kidx_r;
    eq_nxt         = eq_r;
    done_nxt       = done_r;
    we             = 1'b0;
    waddr          = '0;
    emit_val       = 1'b0;
    fin_en         = 1'b0;
    fin_kind       = KIND_FOUND;
    fin_len        = '0;
    klen_base      = key_closed_r ? '0 : key_len_r;
    len_upd        = len_r;
    rem_dec        = rem_r - VLEN_W'(1);
    ak             = 1'b0;
    ak_rem         = '0;

    for (int i = 0; i < 4; i++) begin
      if (32'(bir_r) == i) begin
        len_upd[8*i +: 8] = len_r[8*i +: 8] | b;
      end
    end
    if (32'(bir_r) >= 32'd4 && b != 8'd0) begin
      len_upd = '1;
    end

    if (step) begin
      if (item.req_type == REQ_KEY) begin
        // a key byte abandons any scan in progress
        phase_nxt = PH_LEN;
        bir_nxt   = '0;
        len_nxt   = '0;
        cand_nxt  = '0;
        eq_nxt    = 1'b1;
        done_nxt  = 1'b0;
        key_over_nxt = key_closed_r ? 1'b0 : key_over_r;
        if (32'(klen_base) < KEY_CAPACITY) begin
          we          = 1'b1;
          waddr       = AW'(klen_base);
          key_len_nxt = klen_base + KLW'(1);
        end else begin
          key_len_nxt  = klen_base;
          key_over_nxt = 1'b1;
        end
        key_closed_nxt = item.is_last;
      end else begin
        key_closed_nxt = 1'b1;
        unique case (phase_r)
          PH_LEN: begin
            len_nxt = len_upd;
            bir_nxt = bir_r + BW'(1);
            if (bir_r == BW'(LENGTH_FIELD_BYTES - 1)) begin
              if (len_upd > MAX_REC_LEN || len_upd < LEN_W'(HDR)) begin
                fin_en    = 1'b1;
                fin_kind  = KIND_MALFORMED;
                phase_nxt = PH_DONE;
                done_nxt  = 1'b1;
              end else begin
                phase_nxt = PH_KLEN;
                rem_nxt   = VLEN_W'(len_upd - LEN_W'(HDR));
              end
            end
          end
          PH_KLEN: begin
            cand_nxt = b;
            if (32'(b) > KEY_CAPACITY || VLEN_W'(b) > rem_r) begin
              fin_en    = 1'b1;
              fin_kind  = KIND_MALFORMED;
              phase_nxt = PH_DONE;
              done_nxt  = 1'b1;
            end else begin
              eq_nxt = (9'(b) == 9'(key_len_r)) && !key_over_r;
              if (b == 8'd0) begin
                ak     = 1'b1;
                ak_rem = rem_r;
              end else begin
                phase_nxt = PH_KEY;
                kidx_nxt  = '0;
              end
            end
          end
          PH_KEY: begin
            if (9'(kidx_r) >= 9'(key_len_r) || key_rdata != b) begin
              eq_nxt = 1'b0;
            end
            rem_nxt  = rem_dec;
            kidx_nxt = kidx_r + AW'(1);
            if ({1'b0, cand_r} == 9'(kidx_r) + 9'd1) begin
              ak     = 1'b1;
              ak_rem = rem_dec;
            end
          end
          PH_VALUE: begin
            emit_val = 1'b1;
            rem_nxt  = rem_dec;
            if (rem_dec == '0) begin
              fin_en    = 1'b1;
              fin_kind  = KIND_FOUND;
              fin_len   = vlen_r;
              phase_nxt = PH_DONE;
              done_nxt  = 1'b1;
            end
          end
          PH_SKIP: begin
            rem_nxt = rem_dec;
            if (rem_dec == '0) begin
              phase_nxt = PH_LEN;
              bir_nxt   = '0;
              len_nxt   = '0;
              cand_nxt  = '0;
              eq_nxt    = 1'b1;
            end
          end
          default: begin
          end
        endcase

        // candidate key fully passed
        if (ak) begin
          if (eq_nxt) begin
            if (ak_rem == '0) begin
              fin_en    = 1'b1;
              fin_kind  = KIND_FOUND;
              phase_nxt = PH_DONE;
              done_nxt  = 1'b1;
            end else begin
              phase_nxt = PH_VALUE;
              vlen_nxt  = ak_rem;
              rem_nxt   = ak_rem;
            end
          end else if (ak_rem == '0) begin
            phase_nxt = PH_LEN;
            bir_nxt   = '0;
            len_nxt   = '0;
            cand_nxt  = '0;
            eq_nxt    = 1'b1;
          end else begin
            phase_nxt = PH_SKIP;
            rem_nxt   = ak_rem;
          end
        end

        if (item.is_last) begin
          if (!done_nxt) begin
            fin_en   = 1'b1;
            fin_kind = (phase_nxt == PH_LEN && bir_nxt == '0) ? KIND_NOTFOUND
                                                              : KIND_MALFORMED;
            fin_len  = '0;
          end
          phase_nxt = PH_LEN;
          bir_nxt   = '0;
          len_nxt   = '0;
          cand_nxt  = '0;
          eq_nxt    = 1'b1;
          done_nxt  = 1'b0;
        end
      end
    end
  end

  // Outputs
  always_comb begin
    out_t vres;
    out_t fres;
    vres.kind       = KIND_VALUE;
    vres.value_byte = b;
    vres.value_len  = '0;
    vres.final_res  = 1'b0;
    fres.kind       = fin_kind;
    fres.value_byte = '0;
    fres.value_len  = fin_len;
    fres.final_res  = 1'b1;
    res.cnt = {1'b0, emit_val} + {1'b0, fin_en};
    res.r0  = emit_val ? vres : fres;
    res.r1  = fres;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_len_r    <= '0;
      key_over_r   <= 1'b0;
      key_closed_r <= 1'b0;
      phase_r      <= PH_LEN;
      bir_r        <= '0;
      len_r        <= '0;
      rem_r        <= '0;
      vlen_r       <= '0;
      cand_r       <= '0;
      kidx_r       <= '0;
      eq_r         <= 1'b1;
      done_r       <= 1'b0;
    end else begin
      key_len_r    <= key_len_nxt;
      key_over_r   <= key_over_nxt;
      key_closed_r <= key_closed_nxt;
      phase_r      <= phase_nxt;
      bir_r        <= bir_nxt;
      len_r        <= len_nxt;
      rem_r        <= rem_nxt;
      vlen_r       <= vlen_nxt;
      cand_r       <= cand_nxt;
      kidx_r       <= kidx_nxt;
      eq_r         <= eq_nxt;
      done_r       <= done_nxt;
    end
  end

  a_key_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(key_len_r) <= KEY_CAPACITY)
    else $error("stored key length beyond capacity");

  a_kidx_in_key: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_KEY |-> 9'(kidx_r) < {1'b0, cand_r})
    else $error("key compare index past candidate key length");

  a_rem_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_KEY || phase_r == PH_VALUE || phase_r == PH_SKIP) |-> rem_r != '0)
    else $error("record byte count exhausted inside record body");

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res.cnt == 2'd2) |-> (res.r0.kind == KIND_VALUE && res.r1.final_res))
    else $error("two results from one byte not value then status");

endmodule

### design/record_block_key_search_unit.sv
// Top level of the record block key search unit: input stage, result buffer.
// Depends on rbks_pkg and rbks_scan.
//
// Usage: send the search key as a run of in_data bytes with req_type = key,
// is_last on its final byte. Then stream a block's bytes with req_type =
// block, is_last on the final one. Each record is a little-endian length,
// a key length byte, key bytes and value bytes. On the first matching
// record the unit returns its value bytes (kind value) and then a found
// status carrying the value length; otherwise not found or malformed, with
// final_res set on that status. Later bytes of the block give no output.
// An accepted byte is registered in the input stage; its results are then
// registered in the result buffer. Throughput: one byte per cycle while
// out_ready stays high; a byte that yields a value byte and a status holds off
// the next byte while the two-entry result buffer drains one result per cycle.
// When out_ready is low the buffer holds, the input stage holds its byte
// and in_ready drops once that stage is full.
// Reset (rst_n low, synchronous) clears the stored key length, the scan
// state and both buffers; key bytes stored before reset are not reused.
module record_block_key_search_unit
  import rbks_pkg::*;
#(
  parameter int KEY_CAPACITY       = 128,
  parameter int LENGTH_FIELD_BYTES = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  in_t        a_r;
  logic       a_vld_r, a_vld_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  out_t       slot0_r, slot0_nxt;
  out_t       slot1_r, slot1_nxt;
  logic       fire;
  logic       pop;
  res_pair_t  res;

  // process the staged byte only when the buffer is empty or its single result is being taken
  assign fire      = a_vld_r && (cnt_r == 2'd0 || (cnt_r == 2'd1 && out_ready));
  assign pop       = (cnt_r != 2'd0) && out_ready;
  assign in_ready  = !a_vld_r || fire;
  assign out_valid = cnt_r != 2'd0;
  assign out_data  = slot0_r;

  rbks_scan #(
    .KEY_CAPACITY       (KEY_CAPACITY),
    .LENGTH_FIELD_BYTES (LENGTH_FIELD_BYTES)
  ) u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (fire),
    .item  (a_r),
    .res   (res)
  );

  always_comb begin
    a_vld_nxt = a_vld_r;
    cnt_nxt   = cnt_r;
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    if (in_valid && in_ready) begin
      a_vld_nxt = 1'b1;
    end else if (fire) begin
      a_vld_nxt = 1'b0;
    end
    if (fire) begin
      cnt_nxt   = res.cnt;
      slot0_nxt = res.r0;
      slot1_nxt = res.r1;
    end else if (pop) begin
      cnt_nxt   = cnt_r - 2'd1;
      slot0_nxt = slot1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      cnt_r   <= 2'd0;
    end else begin
      a_vld_r <= a_vld_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_r <= in_data;
    end
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("result buffer count out of range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != 2'd0 && !out_ready) |=> (cnt_r != 2'd0 && $stable(slot0_r)))
    else $error("pending transaction lost while stalled");

  a_stage_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (a_vld_r && cnt_r == 2'd0) |=> (!a_vld_r || $past(in_valid)))
    else $error("staged byte not processed with empty buffer");

endmodule
